@@ hw/rtl/hbsa_pkg.sv @@
// Shared constants and helpers for the hashed bitmap slot allocator.
// No dependencies; imported by every module of the block.
package hbsa_pkg;

    localparam int SIDE_DEF  = 4;   // grid side, SIDE*SIDE bitmap words
    localparam int KEY_W     = 32;
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;   // bit position within a bitmap word
    localparam int OUT_POS_W = 2;   // result column/row field width

    // index width for a store of the given depth, never below one bit
    function automatic int idx_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

@@ hw/rtl/hbsa_front.sv @@
// Front end: accepts keys and hashes them to a start word, column, row and bit.
// Depends on hbsa_pkg.
module hbsa_front #(
    parameter int SIDE = hbsa_pkg::SIDE_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_stall,
    input  logic [hbsa_pkg::KEY_W-1:0]                  i_key,
    output logic                                        o_job_valid,
    input  logic                                        i_job_ready,
    output logic [hbsa_pkg::idx_w(SIDE*SIDE)-1:0]       o_job_word,
    output logic [hbsa_pkg::idx_w(SIDE)-1:0]            o_job_col,
    output logic [hbsa_pkg::idx_w(SIDE)-1:0]            o_job_row,
    output logic [hbsa_pkg::BIT_W-1:0]                  o_job_bit
);
    import hbsa_pkg::*;

    localparam int Words = SIDE * SIDE;
    localparam int RW    = idx_w(Words);
    localparam int CW    = idx_w(SIDE);
    localparam int Lg    = $clog2(Words);
    localparam int PW    = 2 * KEY_W + 1;
    // ceil(2^(KEY_W+Lg) / Words): exact quotient for every key value
    localparam logic [63:0] RecipFull =
        ((64'd1 << (KEY_W + Lg)) + 64'(Words - 1)) / 64'(Words);
    localparam logic [KEY_W:0] Recip = RecipFull[KEY_W:0];

    typedef enum logic [2:0] {S_IDLE, S_QUOT, S_WORD, S_SPLIT, S_PUSH} t_state;

    t_state             r_state;
    logic [KEY_W-1:0]   r_key;
    logic [BIT_W-1:0]   r_bit;
    logic [KEY_W-1:0]   r_quot;
    logic [RW-1:0]      r_word;
    logic [CW-1:0]      r_col;
    logic [CW-1:0]      r_row;

    logic [PW-1:0]      v_prod;
    logic [KEY_W-1:0]   n_quot;
    logic [RW-1:0]      v_rem;
    logic [RW-1:0]      n_word;
    logic [RW-1:0]      v_base;
    logic [CW-1:0]      n_col;
    logic [CW-1:0]      n_row;

    always_comb begin
        // key / Words by reciprocal multiplication
        v_prod = PW'(r_key) * PW'(Recip);
        n_quot = KEY_W'(v_prod >> (KEY_W + Lg));
        // remainder is below Words, so the low RW bits carry it exactly
        v_rem  = r_key[RW-1:0] - RW'(r_quot[RW-1:0] * RW'(Words));
        // index zero wraps to the last word
        n_word = (v_rem == '0) ? RW'(Words - 1) : (v_rem - RW'(1));
        // word = col*SIDE + row: largest column base not above the word
        n_col  = '0;
        v_base = '0;
        for (int c = 1; c < SIDE; c++) begin
            if (r_word >= RW'(c * SIDE)) begin
                n_col  = CW'(c);
                v_base = RW'(c * SIDE);
            end
        end
        n_row = CW'(r_word - v_base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_key   <= i_key;
                        r_bit   <= i_key[BIT_W-1:0];
                        r_state <= S_QUOT;
                    end
                end
                S_QUOT: begin
                    r_quot  <= n_quot;
                    r_state <= S_WORD;
                end
                S_WORD: begin
                    r_word  <= n_word;
                    r_state <= S_SPLIT;
                end
                S_SPLIT: begin
                    r_col   <= n_col;
                    r_row   <= n_row;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_job_valid = (r_state == S_PUSH);
    assign o_job_word  = r_word;
    assign o_job_col   = r_col;
    assign o_job_row   = r_row;
    assign o_job_bit   = r_bit;

    a_word_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> (r_word <= RW'(Words - 1)))
        else $error("front: start word out of range");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> (r_col <= CW'(SIDE - 1) && r_row <= CW'(SIDE - 1)))
        else $error("front: column or row out of range");

endmodule

@@ hw/rtl/hbsa_queue.sv @@
// Two-entry job queue between the hashing front end and the scan back end.
// Imports hbsa_pkg but uses none of it; data is an opaque vector.
module hbsa_queue #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  logic [DW-1:0] i_push_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output logic [DW-1:0] o_pop_data
);
    import hbsa_pkg::*;

    logic [DW-1:0] r_data [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_count;

    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_data[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_data[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue: occupancy overflow");

endmodule

@@ hw/rtl/hbsa_back.sv @@
// Back end: owns the occupancy bitmap, scans one word per cycle for a clear bit,
// sets it or flags full, holds the result in an output register. Uses hbsa_pkg.
module hbsa_back #(
    parameter int SIDE = hbsa_pkg::SIDE_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_job_valid,
    output logic                                        o_job_ready,
    input  logic [hbsa_pkg::idx_w(SIDE*SIDE)-1:0]       i_job_word,
    input  logic [hbsa_pkg::idx_w(SIDE)-1:0]            i_job_col,
    input  logic [hbsa_pkg::idx_w(SIDE)-1:0]            i_job_row,
    input  logic [hbsa_pkg::BIT_W-1:0]                  i_job_bit,
    output logic                                        o_valid,
    input  logic                                        i_stall,
    output logic [hbsa_pkg::OUT_POS_W-1:0]              o_slot_col,
    output logic [hbsa_pkg::OUT_POS_W-1:0]              o_slot_row,
    output logic [hbsa_pkg::BIT_W-1:0]                  o_slot_bit,
    output logic                                        o_full_res
);
    import hbsa_pkg::*;

    localparam int Words = SIDE * SIDE;
    localparam int RW    = idx_w(Words);
    localparam int CW    = idx_w(SIDE);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} t_state;

    t_state                 r_state;
    logic [WORD_BITS-1:0]   r_mem [Words];
    logic [Words-1:0]       r_vld;
    logic [BIT_W-1:0]       r_bit;

    // issue stage: next word address to read
    logic                   r_iss_on;
    logic                   r_iss_first;
    logic [RW-1:0]          r_iss_addr;
    logic [CW-1:0]          r_iss_col;
    logic [CW-1:0]          r_iss_row;

    // check stage: word whose data sits in r_rdata
    logic                   r_chk_on;
    logic                   r_chk_first;
    logic                   r_chk_last;
    logic [RW-1:0]          r_chk_addr;
    logic [CW-1:0]          r_chk_col;
    logic [CW-1:0]          r_chk_row;
    logic [WORD_BITS-1:0]   r_rdata;
    logic                   r_rvld;

    logic [OUT_POS_W-1:0]   r_res_col;
    logic [OUT_POS_W-1:0]   r_res_row;
    logic [BIT_W-1:0]       r_res_bit;
    logic                   r_res_full;

    logic                   r_out_valid;
    logic [OUT_POS_W-1:0]   r_out_col;
    logic [OUT_POS_W-1:0]   r_out_row;
    logic [BIT_W-1:0]       r_out_bit;
    logic                   r_out_full;

    logic [WORD_BITS-1:0]   v_word;
    logic [WORD_BITS-1:0]   v_mask;
    logic [WORD_BITS-1:0]   v_free;
    logic [BIT_W-1:0]       hit_bit;
    logic                   hit;
    logic                   miss_last;
    logic                   do_write;
    logic [WORD_BITS-1:0]   n_word;

    // a never-written word reads as all clear
    always_comb begin
        v_word  = r_rvld ? r_rdata : '0;
        v_mask  = r_chk_first ? ((WORD_BITS'(1) << r_bit) - WORD_BITS'(1)) : '0;
        v_free  = ~(v_word | v_mask);
        hit_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v_free[i]) begin
                hit_bit = BIT_W'(i);
            end
        end
        hit       = (r_state == S_SCAN) && r_chk_on && (v_free != '0);
        miss_last = (r_state == S_SCAN) && r_chk_on && (v_free == '0) && r_chk_last;
        do_write  = hit;
        n_word    = v_word | (WORD_BITS'(1) << hit_bit);
    end

    // bitmap storage, read one word per cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_iss_addr];
        if (do_write) begin
            r_mem[r_chk_addr] <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[r_iss_addr];
            if (do_write) begin
                r_vld[r_chk_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iss_on    <= 1'b0;
            r_chk_on    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_iss_addr  <= i_job_word;
                        r_iss_col   <= i_job_col;
                        r_iss_row   <= i_job_row;
                        r_bit       <= i_job_bit;
                        r_iss_on    <= 1'b1;
                        r_iss_first <= 1'b1;
                        r_chk_on    <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_iss_on) begin
                        r_chk_on    <= 1'b1;
                        r_chk_first <= r_iss_first;
                        r_chk_addr  <= r_iss_addr;
                        r_chk_col   <= r_iss_col;
                        r_chk_row   <= r_iss_row;
                        r_chk_last  <= (r_iss_addr == RW'(Words - 1));
                        r_iss_first <= 1'b0;
                        if (r_iss_addr == RW'(Words - 1)) begin
                            r_iss_on <= 1'b0;
                        end else begin
                            r_iss_addr <= r_iss_addr + RW'(1);
                            if (r_iss_row == CW'(SIDE - 1)) begin
                                r_iss_row <= '0;
                                r_iss_col <= r_iss_col + CW'(1);
                            end else begin
                                r_iss_row <= r_iss_row + CW'(1);
                            end
                        end
                    end else begin
                        r_chk_on <= 1'b0;
                    end
                    if (hit) begin
                        r_res_col  <= OUT_POS_W'(r_chk_col);
                        r_res_row  <= OUT_POS_W'(r_chk_row);
                        r_res_bit  <= hit_bit;
                        r_res_full <= 1'b0;
                        r_iss_on   <= 1'b0;
                        r_state    <= S_EMIT;
                    end else if (miss_last) begin
                        r_res_col  <= '0;
                        r_res_row  <= '0;
                        r_res_bit  <= '0;
                        r_res_full <= 1'b1;
                        r_iss_on   <= 1'b0;
                        r_state    <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_col   <= r_res_col;
                        r_out_row   <= r_res_row;
                        r_out_bit   <= r_res_bit;
                        r_out_full  <= r_res_full;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_job_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_slot_col  = r_out_col;
    assign o_slot_row  = r_out_row;
    assign o_slot_bit  = r_out_bit;
    assign o_full_res  = r_out_full;

    a_hit_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hit || miss_last) |=> (r_state == S_EMIT))
        else $error("back: scan end did not move to emit");

    a_write_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |=> (r_vld[$past(r_chk_addr)] == 1'b1))
        else $error("back: written word not marked valid");

endmodule

@@ hw/rtl/hashed_bitmap_slot_allocator.sv @@
// Hashed bitmap slot allocator top: hash front, job queue, scan back end (hbsa_pkg).
// Path: front steps (quotient, wrap, col/row split, push), the job queue, a scan of the
// n words probed (1..SIDE*SIDE) from the start word upward, then the emit register.
// The bitmap is read one word per scan step; the back end takes a new job only once
// the last result is emitted. A stalled output backs up through queue and front.
// Reset (sync, active low): control and per-word valid flags are cleared.
module hashed_bitmap_slot_allocator #(
    parameter int SIDE = hbsa_pkg::SIDE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [hbsa_pkg::KEY_W-1:0]        i_key,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [hbsa_pkg::OUT_POS_W-1:0]    o_slot_col,
    output logic [hbsa_pkg::OUT_POS_W-1:0]    o_slot_row,
    output logic [hbsa_pkg::BIT_W-1:0]        o_slot_bit,
    output logic                              o_full_res
);
    import hbsa_pkg::*;

    localparam int Words = SIDE * SIDE;
    localparam int RW    = idx_w(Words);
    localparam int CW    = idx_w(SIDE);
    localparam int DW    = RW + 2 * CW + BIT_W;   // queued job: word, col, row, bit

    // front -> queue
    logic               f_valid;
    logic               f_ready;
    logic [RW-1:0]      f_word;
    logic [CW-1:0]      f_col;
    logic [CW-1:0]      f_row;
    logic [BIT_W-1:0]   f_bit;

    // queue -> back
    logic               q_valid;
    logic               q_ready;
    logic [DW-1:0]      q_data;

    hbsa_front #(
        .SIDE (SIDE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_key       (i_key),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job_word  (f_word),
        .o_job_col   (f_col),
        .o_job_row   (f_row),
        .o_job_bit   (f_bit)
    );

    // decouples hashing from the scan so each side stalls on its own
    hbsa_queue #(
        .DW (DW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  ({f_word, f_col, f_row, f_bit}),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    hbsa_back #(
        .SIDE (SIDE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job_word  (q_data[DW-1 -: RW]),
        .i_job_col   (q_data[BIT_W + 2*CW - 1 -: CW]),
        .i_job_row   (q_data[BIT_W + CW - 1 -: CW]),
        .i_job_bit   (q_data[BIT_W-1:0]),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_slot_col  (o_slot_col),
        .o_slot_row  (o_slot_row),
        .o_slot_bit  (o_slot_bit),
        .o_full_res  (o_full_res)
    );

    // a full result reports slot zero
    a_full_zero_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_full_res) |->
            (o_slot_col == '0 && o_slot_row == '0 && o_slot_bit == '0))
        else $error("top: full result carries a nonzero slot");

endmodule

@@ tb/sv/hashed_bitmap_slot_allocator_test.sv @@
// Self-checking testbench for hashed_bitmap_slot_allocator.
// Holds a scoreboard with its own copy of the occupancy bitmap and drives stall/valid
// traffic with random gaps. Depends on hbsa_pkg and the allocator RTL.
module hashed_bitmap_slot_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hbsa_pkg::*;

    localparam int SIDE         = SIDE_DEF;
    localparam int WORD_COUNT   = SIDE * SIDE;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_AFTER   = 150;      // accepted keys before the long receiver hold-off
    localparam int HOLD_CYCLES  = 300;      // length of that hold-off
    localparam int DRAIN_CYCLES = 40;       // longer than the worst-case latency with no output stall
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TIMEOUT_NS   = 5_000_000;

    // One grant as the block reports it.
    typedef struct {
        logic [OUT_POS_W-1:0] col;
        logic [OUT_POS_W-1:0] row;
        logic [BIT_W-1:0]     slot_bit;
        logic                 full;
    } t_slot_grant;

    // Tracks the bitmap, predicts the grant for every accepted key and checks results
    // in order against the queue of pending grants.
    class slot_grant_scoreboard;
        bit [WORD_BITS-1:0] occupancy [WORD_COUNT];
        t_slot_grant        grant_q [$];
        int                 errors;

        function new();
            errors = 0;
            foreach (occupancy[i]) occupancy[i] = '0;
        endfunction

        // Hash to a start word/bit, then linear probe upward with no wrap past the last word.
        function void note_key(input logic [KEY_W-1:0] key);
            int unsigned w;
            int unsigned b;
            bit          found;
            t_slot_grant g;
            w = ((key % WORD_COUNT) + WORD_COUNT - 1) % WORD_COUNT;
            b = key % WORD_BITS;
            found = 1'b0;
            while (!found && w < WORD_COUNT) begin
                if (!occupancy[w][b]) begin
                    found = 1'b1;
                end else if (b == WORD_BITS - 1) begin
                    w++;
                    b = 0;
                end else begin
                    b++;
                end
            end
            if (found) begin
                occupancy[w][b] = 1'b1;
                g.col      = OUT_POS_W'(w / SIDE);
                g.row      = OUT_POS_W'(w % SIDE);
                g.slot_bit = BIT_W'(b);
                g.full     = 1'b0;
            end else begin
                // nothing free from the start slot onward: bitmap untouched
                g.col      = '0;
                g.row      = '0;
                g.slot_bit = '0;
                g.full     = 1'b1;
            end
            grant_q.push_back(g);
        endfunction

        function void compare_field(input string name, input logic [31:0] expv,
                                    input logic [31:0] got);
            if (got !== expv) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, got);
                errors++;
            end
        endfunction

        function void check_result(input logic [OUT_POS_W-1:0] col,
                                   input logic [OUT_POS_W-1:0] row,
                                   input logic [BIT_W-1:0] sbit, input logic full);
            t_slot_grant g;
            if (grant_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0d/%0d/%0d/%0b",
                         $time, col, row, sbit, full);
                errors++;
                return;
            end
            g = grant_q.pop_front();
            compare_field("slot_col", 32'(g.col), 32'(col));
            compare_field("slot_row", 32'(g.row), 32'(row));
            compare_field("slot_bit", 32'(g.slot_bit), 32'(sbit));
            compare_field("full_res", 32'(g.full), 32'(full));
        endfunction

        function int outstanding();
            return grant_q.size();
        endfunction

        function void close_out();
            if (grant_q.size() != 0) begin
                $display("%0t: %0d results missing, expected %0d actual 0",
                         $time, grant_q.size(), grant_q.size());
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [KEY_W-1:0]     i_key;
    logic                 o_valid;
    logic                 i_stall;
    logic [OUT_POS_W-1:0] o_slot_col;
    logic [OUT_POS_W-1:0] o_slot_row;
    logic [BIT_W-1:0]     o_slot_bit;
    logic                 o_full_res;

    slot_grant_scoreboard sb;
    int                   keys_accepted;
    bit                   burst_mode;   // both sides run flat out while set
    bit                   hold_done;

    hashed_bitmap_slot_allocator #(
        .SIDE(SIDE)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_key      (i_key),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_slot_col (o_slot_col),
        .o_slot_row (o_slot_row),
        .o_slot_bit (o_slot_bit),
        .o_full_res (o_full_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // Idle cycles ahead of a transfer: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one key, hold it steady until accepted. Entered and left at a falling edge,
    // so back-to-back transfers keep i_valid high without dropping it.
    task automatic send_key(input logic [KEY_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_key   = key;
        do @(posedge i_clk); while (o_stall);
        sb.note_key(key);
        keys_accepted++;
        @(negedge i_clk);
    endtask

    // Result sampling: values read right at the rising edge are the pre-edge ones.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_slot_col, o_slot_row, o_slot_bit, o_full_res);
        end
    end

    // Receiver back-pressure. One long hold-off early on lets the block fill up and
    // stall its input while the sender keeps offering keys.
    initial begin
        int r;
        int len;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && keys_accepted >= HOLD_AFTER) begin
                i_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (burst_mode) begin
                i_stall = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    i_stall = 1'b0;
                    len = $urandom_range(1, 20);
                end else if (r < 95) begin
                    i_stall = 1'b1;
                    len = $urandom_range(1, 3);
                end else begin
                    i_stall = 1'b1;
                    len = $urandom_range(20, 60);
                end
                repeat (len - 1) @(negedge i_clk);
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] key;
        int               r;
        int               waited;
        sb            = new();
        keys_accepted = 0;
        burst_mode    = 1'b0;
        hold_done     = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_key         = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: key 16 hashes to index zero, so its start word wraps to the last word
        // at bit 16. Sixteen of them fill bits 16..31 there; the next finds nothing free.
        repeat (16) send_key(32'd16);
        send_key(32'd16);
        send_key(32'hFFFF_FFF0);        // same start slot, also full
        send_key(32'd0);                // last word, bit 0
        send_key(32'hFFFF_FFFF);        // word 14, top bit
        send_key(32'hFFFF_FFFF);        // top bit taken, probe crosses into word 15
        send_key(32'd1);                // word 0, bit 1
        send_key(32'd31);               // word 14 top bit again, spills over
        send_key(32'h8000_0000);        // index zero with a high key bit set

        // Random: full-range keys, repeats that force long probes, and low keys in 0..63 that
        // start anywhere in the map. The map fills as the run goes, so full results grow common.
        key = '0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            burst_mode = (i >= 400 && i < 500);
            r = $urandom_range(0, 99);
            if (r < 20) begin
                key = key;
            end else if (r < 30) begin
                key = $urandom_range(0, 63);
            end else begin
                key = $urandom;
            end
            send_key(key);
        end
        burst_mode = 1'b0;
        i_valid    = 1'b0;

        waited = 0;
        while (sb.outstanding() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.close_out();
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ hashed_bitmap_slot_allocator.f @@
hw/rtl/hbsa_pkg.sv
hw/rtl/hbsa_front.sv
hw/rtl/hbsa_queue.sv
hw/rtl/hbsa_back.sv
hw/rtl/hashed_bitmap_slot_allocator.sv
tb/sv/hashed_bitmap_slot_allocator_test.sv
